// ----- rtl/rbd_pkg.sv -----
// ----------------------------------------------------------------------------
// rbd_pkg : shared types and codes for the ring buffer deque
// Operation codes, result status codes and controller/datapath bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package rbd_pkg;

  localparam int DATA_W = 32;
  localparam int FUNC_W = 3;
  localparam int STAT_W = 2;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH_FRONT = 3'd0,
    FN_PUSH_BACK  = 3'd1,
    FN_POP_FRONT  = 3'd2,
    FN_POP_BACK   = 3'd3,
    FN_PEEK_FRONT = 3'd4,
    FN_PEEK_BACK  = 3'd5,
    FN_EMPTY      = 3'd6,
    FN_SIZE       = 3'd7
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK         = 2'd0,
    ST_READ_EMPTY = 2'd1,
    ST_PUSH_FULL  = 2'd2,
    ST_RSVD       = 2'd3
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic exec;     // request accepted: run the operation
    logic load_rd;  // store read data is valid: capture it
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_read; // operation reads the store
  } sts_t;

endpackage

`default_nettype wire

// ----- rtl/rbd_ram.sv -----
// ----------------------------------------------------------------------------
// rbd_ram : generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rbd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/rbd_ctrl.sv -----
// ----------------------------------------------------------------------------
// rbd_ctrl : deque controller
// Sequences one request at a time: accept, optional store read, result.
// ----------------------------------------------------------------------------
`default_nettype none

module rbd_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output rbd_pkg::cmd_t      cmd,
  input  wire rbd_pkg::sts_t sts
);

  import rbd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready   = (state_r == S_IDLE);
  assign out_tvalid  = (state_r == S_OUT);
  assign cmd.exec    = in_tvalid && in_tready;
  assign cmd.load_rd = (state_r == S_READ);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = sts.need_read ? S_READ : S_OUT;
        end
      end
      S_READ: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/rbd_dpath.sv -----
// ----------------------------------------------------------------------------
// rbd_dpath : deque datapath
// Front/back pointers, element count, element store and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rbd_dpath #(
  parameter int DEPTH = 1024
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire rbd_pkg::func_t              func,
  input  wire logic [rbd_pkg::DATA_W-1:0]  push_value,
  input  wire rbd_pkg::cmd_t               cmd,
  output rbd_pkg::sts_t                    sts,
  output logic      [rbd_pkg::DATA_W-1:0]  read_value_r,
  output rbd_pkg::status_t                 status_r,
  output logic                             is_empty_r,
  output logic      [$clog2(DEPTH+1)-1:0]  fill_count_r
);

  import rbd_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [PTR_W-1:0]  head_r, head_nxt;
  logic [PTR_W-1:0]  tail_r, tail_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [PTR_W-1:0]  head_inc, head_dec, tail_inc, tail_dec;
  logic              empty, full;
  logic              ram_we;
  logic [PTR_W-1:0]  ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_rdata;
  status_t           status_nxt;

  assign empty = (count_r == '0);
  assign full  = (count_r == CNT_FULL);

  assign head_inc = (head_r == PTR_LAST) ? '0 : head_r + 1'b1;
  assign head_dec = (head_r == '0) ? PTR_LAST : head_r - 1'b1;
  assign tail_inc = (tail_r == PTR_LAST) ? '0 : tail_r + 1'b1;
  assign tail_dec = (tail_r == '0) ? PTR_LAST : tail_r - 1'b1;

  always_comb begin
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    ram_we        = 1'b0;
    ram_waddr     = tail_r;
    ram_raddr     = head_r;
    status_nxt    = ST_OK;
    sts.need_read = 1'b0;
    case (func) inside
      FN_PUSH_FRONT, FN_PUSH_BACK: begin
        if (full) begin
          status_nxt = ST_PUSH_FULL;
        end else begin
          ram_we    = cmd.exec;
          count_nxt = count_r + 1'b1;
          if (func == FN_PUSH_FRONT) begin
            head_nxt  = head_dec;
            ram_waddr = head_dec;
          end else begin
            tail_nxt  = tail_inc;
            ram_waddr = tail_r;
          end
        end
      end
      FN_POP_FRONT, FN_POP_BACK, FN_PEEK_FRONT, FN_PEEK_BACK: begin
        if (empty) begin
          status_nxt = ST_READ_EMPTY;
        end else begin
          sts.need_read = 1'b1;
          if (func == FN_POP_FRONT || func == FN_PEEK_FRONT) begin
            ram_raddr = head_r;
          end else begin
            ram_raddr = tail_dec;
          end
          if (func == FN_POP_FRONT) begin
            head_nxt  = head_inc;
            count_nxt = count_r - 1'b1;
          end else if (func == FN_POP_BACK) begin
            tail_nxt  = tail_dec;
            count_nxt = count_r - 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  rbd_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (push_value),
    .raddr   (ram_raddr),
    .rdata_r (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else if (cmd.exec) begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  // result register; store read data is captured from the registered store output in S_READ
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      read_value_r <= (status_nxt == ST_READ_EMPTY) ? '1 : '0;
      status_r     <= status_nxt;
      is_empty_r   <= (count_nxt == '0);
      fill_count_r <= count_nxt;
    end else if (cmd.load_rd) begin
      read_value_r <= ram_rdata;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ring_buffer_deque.sv -----
// ----------------------------------------------------------------------------
// ring_buffer_deque : double-ended queue in a circular store
// Push/pop/peek at either end, empty and size queries; one result per request.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata (low bit up)                       | tuser
//  --------+-----+------------------------------------------+----------
//  in_     | in  | push_value[31:0]                         | func[2:0]
//  out_    | out | read_value, status, is_empty, fill_count | -
//
//  A request that reads the store (non-empty pop or peek) passes through the
//  read and result states before the controller is idle for the next
//  acceptance; any other request skips the read state, the registered store read.
//  One request is in flight at a time; out_tvalid holds until out_tready.
//  Reset (rst_n low, synchronous) empties the deque; store contents are not
//  cleared and need no clearing pass, as only written entries are ever read.
//
`default_nettype none

module ring_buffer_deque #(
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // request channel
  input  wire logic                     in_tvalid,
  output logic                          in_tready,
  input  wire logic [31:0]              in_tdata,  // push_value[31:0]
  input  wire logic [2:0]               in_tuser,  // func[2:0]
  // result channel
  output logic                          out_tvalid,
  input  wire logic                     out_tready,
  // read_value[31:0], status[33:32], is_empty[34], fill_count[35 +: CNT_W],
  // zero padding to whole bytes
  output logic [((35 + $clog2(DEPTH+1) + 7) / 8) * 8 - 1:0] out_tdata
);

  import rbd_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int RES_W = DATA_W + STAT_W + 1 + CNT_W;
  localparam int OUT_W = ((RES_W + 7) / 8) * 8;

  cmd_t              cmd;
  sts_t              sts;
  logic [DATA_W-1:0] read_value;
  status_t           status;
  logic              is_empty;
  logic [CNT_W-1:0]  fill_count;

  rbd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  rbd_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .func         (func_t'(in_tuser)),
    .push_value   (in_tdata),
    .cmd          (cmd),
    .sts          (sts),
    .read_value_r (read_value),
    .status_r     (status),
    .is_empty_r   (is_empty),
    .fill_count_r (fill_count)
  );

  // pack the result, first field lowest
  assign out_tdata = OUT_W'({fill_count, is_empty, status, read_value});

endmodule

`default_nettype wire
